FILE: hdl/wfu_pkg.sv
package wfu_pkg;

    localparam int LengthWidthDefault = 64;
    localparam int QueueDepth = 2;

    localparam logic [7:0] MaskBit    = 8'd128;
    localparam logic [6:0] LenCode16  = 7'd126;
    localparam logic [6:0] LenCode64  = 7'd127;
    localparam logic [2:0] MaskLast   = 3'd3;
    localparam logic [2:0] Ext16Last  = 3'd1;
    localparam logic [2:0] Ext64Last  = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic       last;
        logic       empty;
        logic       err;
    } t_entry;

endpackage

FILE: hdl/websocket_frame_unmasker_core.sv
// Client-to-server WebSocket frame unmasker. Takes one stream byte per cycle
// while o_stall is low and gives one beat per payload byte (unmasked, last byte
// flagged), one beat for an unmasked frame and one for a zero-length frame;
// header, length and mask bytes give no beat. From an accepted byte to its beat,
// the parser registers its state and pushes into a two-entry queue, and the
// output register applies the mask. Sustained rate is one byte per cycle; input
// stall rises only while the queue is full because the output side is stalled.
module websocket_frame_unmasker_core #(
    parameter int LENGTH_WIDTH = wfu_pkg::LengthWidthDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_stream_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_payload_byte,
    output logic       o_frame_last,
    output logic       o_empty_frame,
    output logic       o_unmasked_error
);

    logic            q_push, q_full, q_pop, q_head_valid;
    wfu_pkg::t_entry q_entry, q_head;

    wfu_front #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_stream_byte(i_stream_byte),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_entry      (q_entry)
    );

    wfu_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_entry     (q_entry),
        .i_pop       (q_pop),
        .o_full      (q_full),
        .o_head_valid(q_head_valid),
        .o_head      (q_head)
    );

    wfu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (q_head_valid),
        .i_head          (q_head),
        .o_pop           (q_pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_payload_byte  (o_payload_byte),
        .o_frame_last    (o_frame_last),
        .o_empty_frame   (o_empty_frame),
        .o_unmasked_error(o_unmasked_error)
    );

    assign o_stall = q_full;

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    a_flag_beat_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_empty_frame || o_unmasked_error)) |->
            (o_frame_last && o_payload_byte == 8'd0))
        else $error("error or empty beat malformed");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_empty_frame && o_unmasked_error))
        else $error("empty and error flags both set");

    a_pop_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_valid)
        else $error("popped entry did not reach output");

endmodule

FILE: hdl/wfu_front.sv
module wfu_front #(
    parameter int LENGTH_WIDTH = wfu_pkg::LengthWidthDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_stream_byte,
    input  logic            i_full,
    output logic            o_push,
    output wfu_pkg::t_entry o_entry
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_EXT16,
        PH_EXT64,
        PH_MASK,
        PH_PAYLOAD
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [LENGTH_WIDTH-1:0] r_len, n_len;
    logic                    r_ovf, n_ovf;
    logic [31:0]             r_key, n_key;
    logic [2:0]              r_cnt, n_cnt;
    logic [1:0]              r_pos, n_pos;

    logic                    accept;
    logic                    push_c;
    wfu_pkg::t_entry         entry_c;
    logic [LENGTH_WIDTH-1:0] shifted;
    logic [2:0]              last_index;
    logic [7:0]              key_byte;

    assign accept  = i_valid && !i_full;
    assign shifted = {r_len[LENGTH_WIDTH-9:0], i_stream_byte};

    always_comb begin
        case (r_pos)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_len      = r_len;
        n_ovf      = r_ovf;
        n_key      = r_key;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        push_c     = 1'b0;
        entry_c    = '0;
        last_index = (r_phase == PH_EXT16) ? wfu_pkg::Ext16Last : wfu_pkg::Ext64Last;
        case (r_phase)
            PH_LENGTH: begin
                n_cnt = '0;
                n_len = '0;
                n_ovf = 1'b0;
                if ((i_stream_byte & wfu_pkg::MaskBit) == 8'd0) begin
                    push_c        = 1'b1;
                    entry_c.last  = 1'b1;
                    entry_c.err   = 1'b1;
                    n_phase       = PH_HEADER;
                end else if (i_stream_byte[6:0] == wfu_pkg::LenCode16) begin
                    n_phase = PH_EXT16;
                end else if (i_stream_byte[6:0] == wfu_pkg::LenCode64) begin
                    n_phase = PH_EXT64;
                end else begin
                    n_len   = {{(LENGTH_WIDTH-7){1'b0}}, i_stream_byte[6:0]};
                    n_phase = PH_MASK;
                end
            end
            PH_EXT16, PH_EXT64: begin
                // saturate once any set bit leaves the top of the length register
                n_ovf = r_ovf || (|r_len[LENGTH_WIDTH-1:LENGTH_WIDTH-8]);
                n_len = shifted;
                if (r_cnt >= last_index) begin
                    if (n_ovf) begin
                        n_len = '1;
                    end
                    n_cnt   = '0;
                    n_phase = PH_MASK;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            PH_MASK: begin
                n_key = {r_key[23:0], i_stream_byte};
                if (r_cnt >= wfu_pkg::MaskLast) begin
                    n_cnt = '0;
                    n_pos = '0;
                    if (r_len == '0) begin
                        push_c        = 1'b1;
                        entry_c.last  = 1'b1;
                        entry_c.empty = 1'b1;
                        n_phase       = PH_HEADER;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            PH_PAYLOAD: begin
                push_c       = 1'b1;
                entry_c.data = i_stream_byte;
                entry_c.key  = key_byte;
                entry_c.last = (r_len == {{(LENGTH_WIDTH-1){1'b0}}, 1'b1});
                n_pos        = r_pos + 2'd1;
                n_len        = r_len - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
                if (entry_c.last) begin
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                n_phase = PH_LENGTH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_key   <= '0;
            r_cnt   <= '0;
            r_pos   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_key   <= n_key;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
        end
    end

    assign o_push  = accept && push_c;
    assign o_entry = entry_c;

endmodule

FILE: hdl/wfu_queue.sv
module wfu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wfu_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_head_valid,
    output wfu_pkg::t_entry o_head
);

    localparam int PtrWidth = $clog2(wfu_pkg::QueueDepth);
    localparam int CntWidth = $clog2(wfu_pkg::QueueDepth + 1);

    wfu_pkg::t_entry       r_mem [wfu_pkg::QueueDepth];
    logic [PtrWidth-1:0]   r_wr, r_rd;
    logic [CntWidth-1:0]   r_count;
    logic                  do_push, do_pop;

    assign o_full       = (r_count == CntWidth'(wfu_pkg::QueueDepth));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrWidth'(wfu_pkg::QueueDepth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrWidth'(wfu_pkg::QueueDepth - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/wfu_back.sv
module wfu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  wfu_pkg::t_entry i_head,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [7:0]      o_payload_byte,
    output logic            o_frame_last,
    output logic            o_empty_frame,
    output logic            o_unmasked_error
);

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last, r_empty, r_err;

    // refill the output register when it is empty or its beat leaves this cycle
    assign o_pop = i_head_valid && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data  <= i_head.data ^ i_head.key;
            r_last  <= i_head.last;
            r_empty <= i_head.empty;
            r_err   <= i_head.err;
        end
    end

    assign o_valid          = r_valid;
    assign o_payload_byte   = r_data;
    assign o_frame_last     = r_last;
    assign o_empty_frame    = r_empty;
    assign o_unmasked_error = r_err;

endmodule
